// ===== sv/elg_pkg.sv =====
// Shared types and constants for the ElGamal sign-and-verify core.
`default_nettype none
package elg_pkg;
	localparam int unsigned NUM_REGS = 3;
	localparam logic [1:0] REG_MODULUS   = 2'd0;
	localparam logic [1:0] REG_GENERATOR = 2'd1;
	localparam logic [1:0] REG_PRIV_KEY  = 2'd2;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,     // latch operands, set up p, n, g
		OP_POW_Y,    // y = g^x mod p
		OP_GCD,      // gcd(k, n)
		OP_INC_K,    // k = k + 1
		OP_POW_R,    // r = g^k mod p
		OP_INV,      // kinv = k^-1 mod n
		OP_XR,       // xr = x*r mod n
		OP_S,        // s = kinv * (m - xr) mod n
		OP_POW_L,    // left = g^m mod p
		OP_POW_YR,   // t = y^r mod p
		OP_POW_RS,   // u = r^s mod p
		OP_RIGHT     // right = t*u mod p
	} elg_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_OUT
	} elg_state_t;

	typedef struct packed {
		logic    start;
		elg_op_t op;
	} elg_cmd_t;

	typedef struct packed {
		logic done;
		logic gcd_one;
	} elg_sts_t;
endpackage
`default_nettype wire

// ===== sv/elg_modunit.sv =====
// Bit-serial modular multiply and restoring divide unit shared by the datapath.
`default_nettype none
module elg_modunit import elg_pkg::*; #(
	parameter int unsigned W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         is_div,   // 1: a / b quotient and remainder, 0: a*b mod md
	input  wire logic [W:0]   a,
	input  wire logic [W:0]   b,
	input  wire logic [W:0]   md,
	output logic              busy,
	output logic              done,
	output logic [W:0]        quo,
	output logic [W:0]        rem
);
	localparam int unsigned CW = $clog2(W + 2);

	logic [W+1:0] acc_q;
	logic [W:0]   a_q, b_q, md_q, quo_q;
	logic [CW-1:0] cnt_q;
	logic          div_q, busy_q, done_q;

	logic [W+2:0] dbl, add_one, red1;
	logic [W+1:0] shr;

	always_comb begin
		// Multiply: acc = 2*acc + msb(a)*b, reduced by up to three subtractions of md.
		dbl     = {acc_q, 1'b0};
		add_one = dbl + (a_q[W] ? {2'b00, b_q} : '0);
		red1    = (add_one >= {2'b00, md_q}) ? add_one - {2'b00, md_q} : add_one;
		if (red1 >= {2'b00, md_q}) begin
			red1 = red1 - {2'b00, md_q};
		end
		if (red1 >= {2'b00, md_q}) begin
			red1 = red1 - {2'b00, md_q};
		end
		// Divide: shift in the next dividend bit.
		shr = {acc_q[W:0], a_q[W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			md_q  <= is_div ? b : md;
			div_q <= is_div;
			acc_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[W-1:0], 1'b0};
			if (div_q) begin
				if (shr >= {1'b0, md_q}) begin
					acc_q <= shr - {1'b0, md_q};
					quo_q <= {quo_q[W-1:0], 1'b1};
				end else begin
					acc_q <= shr;
					quo_q <= {quo_q[W-1:0], 1'b0};
				end
			end else begin
				acc_q <= red1[W+1:0];
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = acc_q[W:0];
endmodule
`default_nettype wire

// ===== sv/elg_datapath.sv =====
// Datapath: operand registers, exponentiation, gcd and inverse sequencing.
`default_nettype none
module elg_datapath import elg_pkg::*; #(
	parameter int unsigned W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire elg_cmd_t     cmd,
	output elg_sts_t          sts,
	input  wire logic [W-1:0] cfg_p,
	input  wire logic [W-1:0] cfg_g,
	input  wire logic [W-1:0] cfg_x,
	input  wire logic [W-1:0] in_m,
	input  wire logic [W-1:0] in_k,
	output logic [W-1:0]      y_o,
	output logic [W:0]        k_o,
	output logic [W-1:0]      r_o,
	output logic [W-1:0]      s_o,
	output logic [W-1:0]      l_o,
	output logic [W-1:0]      rt_o,
	output logic              v_o
);
	localparam int unsigned CW = $clog2(W + 2);

	// Sub-steps inside one operation.
	typedef enum logic [3:0] {
		SS_IDLE, SS_RED, SS_EXP, SS_MUL, SS_SQR,
		SS_GCD, SS_INV, SS_INVM, SS_T, SS_FIN
	} ss_t;

	ss_t         ss_q;
	elg_op_t     op_q;
	logic [W:0]  p_q, n_q, g_q, x_q, m_q, k_q;
	logic [W:0]  y_q, r_q, s_q, l_q, t_q, u_q, rt_q, kinv_q, xr_q;
	logic [W:0]  base_q, acc_q, exp_q;
	logic [W:0]  ga_q, gb_q;
	logic [W:0]  t0_q, t1_q, qq_q;
	logic [CW-1:0] bits_q;
	logic        done_q, one_q;

	logic        mu_start, mu_div, mu_busy, mu_done;
	logic [W:0]  mu_a, mu_b, mu_md, mu_quo, mu_rem;

	elg_modunit #(.W(W)) u_mu (
		.clk(clk), .arst_n(arst_n), .start(mu_start), .is_div(mu_div),
		.a(mu_a), .b(mu_b), .md(mu_md), .busy(mu_busy), .done(mu_done),
		.quo(mu_quo), .rem(mu_rem)
	);

	logic [W:0] p_eff;
	assign p_eff = ({1'b0, cfg_p} < (W+1)'(3)) ? (W+1)'(3) : {1'b0, cfg_p};

	// Next extended-Euclid coefficient t0 - q*t1, kept as a residue mod n.
	logic [W+1:0] tnew_w;
	assign tnew_w = {1'b0, t0_q} + {1'b0, n_q} - {1'b0, mu_rem};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_q   <= SS_IDLE;
			op_q   <= OP_NONE;
			done_q <= 1'b0;
			mu_start <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			mu_start <= 1'b0;
			unique case (ss_q)
				SS_IDLE: begin
					if (cmd.start) begin
						op_q <= cmd.op;
						unique case (cmd.op)
							OP_LOAD: begin
								ss_q <= SS_RED;
								mu_start <= 1'b1;
							end
							OP_INC_K: begin
								ss_q <= SS_FIN;
							end
							OP_GCD: begin
								ss_q <= SS_GCD;
							end
							OP_INV: begin
								ss_q <= SS_INV;
							end
							OP_XR, OP_S, OP_RIGHT: begin
								ss_q <= SS_T;
								mu_start <= 1'b1;
							end
							OP_POW_Y, OP_POW_R, OP_POW_L, OP_POW_YR, OP_POW_RS: begin
								ss_q <= SS_EXP;
							end
							default: ss_q <= SS_FIN;
						endcase
					end
				end
				SS_RED, SS_T: begin
					if (mu_done) begin
						ss_q <= SS_FIN;
					end
				end
				SS_EXP: begin
					if (bits_q == '0) begin
						ss_q <= SS_FIN;
					end else if (exp_q[0]) begin
						ss_q <= SS_MUL;
						mu_start <= 1'b1;
					end else begin
						ss_q <= SS_SQR;
						mu_start <= 1'b1;
					end
				end
				SS_MUL: begin
					if (mu_done) begin
						ss_q <= SS_SQR;
						mu_start <= 1'b1;
					end
				end
				SS_SQR: begin
					if (mu_done) begin
						ss_q <= SS_EXP;
					end
				end
				SS_GCD: begin
					if (gb_q == '0) begin
						ss_q <= SS_FIN;
					end else if (!mu_busy && !mu_start && !mu_done) begin
						mu_start <= 1'b1;
					end
				end
				// One Euclid step: divide, then form q*t1 mod n for the coefficient.
				SS_INV: begin
					if (gb_q == '0) begin
						ss_q <= SS_FIN;
					end else if (mu_done) begin
						ss_q <= SS_INVM;
						mu_start <= 1'b1;
					end else if (!mu_busy && !mu_start) begin
						mu_start <= 1'b1;
					end
				end
				SS_INVM: begin
					if (mu_done) begin
						ss_q <= SS_INV;
					end
				end
				SS_FIN: begin
					ss_q   <= SS_IDLE;
					done_q <= 1'b1;
				end
				default: ss_q <= SS_IDLE;
			endcase
		end
	end

	// Operand selection for the shared unit, sampled while mu_start is high.
	always_comb begin
		mu_div = 1'b0;
		mu_a   = '0;
		mu_b   = '0;
		mu_md  = p_q;
		unique case (ss_q)
			SS_RED: begin
				mu_div = 1'b1;
				mu_a   = {1'b0, cfg_g};
				mu_b   = p_q;
			end
			SS_T: begin
				unique case (op_q)
					OP_XR: begin
						mu_a  = x_q;
						mu_b  = r_q;
						mu_md = n_q;
					end
					OP_S: begin
						// m + n - xr is congruent to m - xr and fits the serial operand.
						mu_a  = m_q + n_q - xr_q;
						mu_b  = kinv_q;
						mu_md = n_q;
					end
					default: begin
						mu_a = t_q;
						mu_b = u_q;
					end
				endcase
			end
			SS_MUL: begin
				mu_a = acc_q;
				mu_b = base_q;
			end
			SS_SQR: begin
				mu_a = base_q;
				mu_b = base_q;
			end
			SS_GCD, SS_INV: begin
				mu_div = 1'b1;
				mu_a   = ga_q;
				mu_b   = gb_q;
			end
			SS_INVM: begin
				mu_a  = qq_q;
				mu_b  = t1_q;
				mu_md = n_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start && ss_q == SS_IDLE) begin
			unique case (cmd.op)
				OP_LOAD: begin
					p_q <= p_eff;
					n_q <= p_eff - 1'b1;
					x_q <= {1'b0, cfg_x};
					m_q <= {1'b0, in_m};
					k_q <= {1'b0, in_k};
				end
				OP_INC_K: k_q <= k_q + 1'b1;
				OP_GCD: begin
					ga_q <= n_q;
					gb_q <= k_q - ((k_q >= n_q) ? n_q : '0);
					one_q <= 1'b0;
				end
				OP_INV: begin
					ga_q <= n_q;
					gb_q <= (k_q >= n_q) ? k_q - n_q : k_q;
					t0_q <= '0;
					t1_q <= (W+1)'(1);
				end
				OP_POW_Y, OP_POW_R, OP_POW_L, OP_POW_YR, OP_POW_RS: begin
					acc_q  <= (W+1)'(1);
					bits_q <= CW'(W + 1);
					unique case (cmd.op)
						OP_POW_Y:  begin base_q <= g_q; exp_q <= x_q; end
						OP_POW_R:  begin base_q <= g_q; exp_q <= k_q; end
						OP_POW_L:  begin base_q <= g_q; exp_q <= m_q; end
						OP_POW_YR: begin base_q <= y_q; exp_q <= r_q; end
						default:   begin base_q <= r_q; exp_q <= s_q; end
					endcase
				end
				default: ;
			endcase
		end
		unique case (ss_q)
			SS_RED: if (mu_done) g_q <= mu_rem;
			SS_T: if (mu_done) begin
				unique case (op_q)
					OP_XR:   xr_q <= mu_rem;
					OP_S:    s_q  <= mu_rem;
					default: rt_q <= mu_rem;
				endcase
			end
			SS_EXP: if (bits_q != '0 && !exp_q[0]) begin
				exp_q  <= exp_q >> 1;
				bits_q <= bits_q - 1'b1;
			end
			SS_MUL: if (mu_done) begin
				acc_q  <= mu_rem;
				exp_q  <= exp_q >> 1;
				bits_q <= bits_q - 1'b1;
			end
			SS_SQR: if (mu_done) base_q <= mu_rem;
			SS_GCD: begin
				if (gb_q == '0) one_q <= (ga_q == (W+1)'(1));
				else if (mu_done) begin
					ga_q <= gb_q;
					gb_q <= mu_rem;
				end
			end
			SS_INV: begin
				if (gb_q == '0) kinv_q <= t0_q;
				else if (mu_done) begin
					qq_q <= mu_quo;
					ga_q <= gb_q;
					gb_q <= mu_rem;
				end
			end
			SS_INVM: if (mu_done) begin
				t0_q <= t1_q;
				t1_q <= (tnew_w >= {1'b0, n_q}) ? tnew_w[W:0] - n_q : tnew_w[W:0];
			end
			SS_FIN: begin
				unique case (op_q)
					OP_POW_Y:  y_q <= acc_q;
					OP_POW_R:  r_q <= acc_q;
					OP_POW_L:  l_q <= acc_q;
					OP_POW_YR: t_q <= acc_q;
					OP_POW_RS: u_q <= acc_q;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign sts.done    = done_q;
	assign sts.gcd_one = one_q;

	assign y_o  = y_q[W-1:0];
	assign k_o  = k_q;
	assign r_o  = r_q[W-1:0];
	assign s_o  = s_q[W-1:0];
	assign l_o  = l_q[W-1:0];
	assign rt_o = rt_q[W-1:0];
	assign v_o  = (l_q == rt_q);
endmodule
`default_nettype wire

// ===== sv/elg_ctrl.sv =====
// Controller state machine that sequences the datapath operations.
`default_nettype none
module elg_ctrl import elg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_fire,
	input  wire logic     out_fire,
	input  wire elg_sts_t sts,
	output elg_cmd_t      cmd,
	output logic          in_ready,
	output logic          out_valid
);
	elg_state_t st_q, st_d;
	elg_op_t    op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			op_q <= OP_NONE;
		end else begin
			st_q <= st_d;
			op_q <= op_d;
		end
	end

	always_comb begin
		st_d = st_q;
		op_d = op_q;
		unique case (st_q)
			// The load is issued in the accepting cycle, so the operands are
			// taken while the input payload is still valid.
			ST_IDLE: if (in_fire) begin
				st_d = ST_WAIT;
				op_d = OP_LOAD;
			end
			ST_ISSUE: st_d = ST_WAIT;
			ST_WAIT: if (sts.done) begin
				st_d = ST_ISSUE;
				unique case (op_q)
					OP_LOAD:   op_d = OP_POW_Y;
					OP_POW_Y:  op_d = OP_GCD;
					OP_GCD:    op_d = sts.gcd_one ? OP_POW_R : OP_INC_K;
					OP_INC_K:  op_d = OP_GCD;
					OP_POW_R:  op_d = OP_INV;
					OP_INV:    op_d = OP_XR;
					OP_XR:     op_d = OP_S;
					OP_S:      op_d = OP_POW_L;
					OP_POW_L:  op_d = OP_POW_YR;
					OP_POW_YR: op_d = OP_POW_RS;
					OP_POW_RS: op_d = OP_RIGHT;
					default:   st_d = ST_OUT;
				endcase
			end
			ST_OUT: if (out_fire) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.start = (st_q == ST_ISSUE) || in_fire;
		cmd.op    = (st_q == ST_IDLE) ? OP_LOAD : op_q;
		in_ready  = (st_q == ST_IDLE);
		out_valid = (st_q == ST_OUT);
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("ready while a result is held");
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> st_q == ST_WAIT)
		else $error("accepted transfer did not start work");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_fire) |=> out_valid)
		else $error("result dropped while stalled");
endmodule
`default_nettype wire

// ===== sv/elgamal_sign_and_verify_core.sv =====
// Top level of the ElGamal sign-and-verify core.
// Usage: configuration writes (index 0 modulus, 1 generator, 2 private key)
// arrive on the cfg channel and are taken in any cycle; they must only be
// issued while the core is idle. A transfer on the input channel carries a
// message and a starting nonce. The core derives the public key, raises the
// nonce until it is coprime with p-1, signs and verifies, and then offers one
// result transfer with all seven output fields.
// Every modular product or division runs through one shared serial unit. An
// exponentiation walks WIDTH+1 exponent bits, and five of them are run. Each
// nonce candidate adds a gcd by Euclid steps, the inverse adds extended Euclid
// steps, and three single products and one reduction of g are added on top.
// Throughput is one item at a time: the next input is taken only after the
// result transfer, as the controller accepts input only while idle.
// Reset returns the registers to p=23, g=5, x=6 and the core to idle.
// While the receiver stalls, the result is held and no input is taken.
`default_nettype none
module elgamal_sign_and_verify_core import elg_pkg::*; #(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [WIDTH-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] message,
	input  wire logic [WIDTH-1:0] nonce,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      public_key,
	output logic [WIDTH:0]        used_nonce,
	output logic [WIDTH-1:0]      sig_r,
	output logic [WIDTH-1:0]      sig_s,
	output logic [WIDTH-1:0]      check_left,
	output logic [WIDTH-1:0]      check_right,
	output logic                  valid_res
);
	logic [WIDTH-1:0] p_q, g_q, x_q;
	elg_cmd_t cmd;
	elg_sts_t sts;

	assign cfg_ready = 1'b1;

	// Configuration registers, written on each cfg transfer to index 0, 1 or 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= WIDTH'(23);
			g_q <= WIDTH'(5);
			x_q <= WIDTH'(6);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODULUS:   p_q <= cfg_data;
				REG_GENERATOR: g_q <= cfg_data;
				REG_PRIV_KEY:  x_q <= cfg_data;
				default: ;
			endcase
		end
	end

	elg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(in_valid && in_ready), .out_fire(out_valid && out_ready),
		.sts(sts), .cmd(cmd), .in_ready(in_ready), .out_valid(out_valid)
	);

	elg_datapath #(.W(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_p(p_q), .cfg_g(g_q), .cfg_x(x_q), .in_m(message), .in_k(nonce),
		.y_o(public_key), .k_o(used_nonce), .r_o(sig_r), .s_o(sig_s),
		.l_o(check_left), .rt_o(check_right), .v_o(valid_res)
	);
endmodule
`default_nettype wire
